// File: design/mms_pkg.sv
// Package for the mbox message splitter: line phase codes, job word format,
// delimiter text lookup and register addresses. No dependencies.
package mms_pkg;

    // Line phase of the input stream.
    typedef enum logic [2:0] {
        PH_START = 3'd0,   // line start, nothing matched
        PH_F     = 3'd1,   // "F" held
        PH_FR    = 3'd2,   // "Fr" held
        PH_FRO   = 3'd3,   // "Fro" held
        PH_FROM  = 3'd4,   // "From" held
        PH_BODY  = 3'd5,   // inside an ordinary line
        PH_DELIM = 3'd6    // inside a delimiter line
    } line_phase_t;

    // Result slots of one job, issued from low to high.
    localparam int SLOT_END_FIRST = 0;   // message end before the delimiter
    localparam int SLOT_TEXT0     = 1;   // slots 1..5 carry "From "
    localparam int SLOT_TAIL      = 6;   // current byte or added newline
    localparam int SLOT_END_LAST  = 7;   // message end at end of stream
    localparam int NUM_SLOTS      = 8;
    localparam int TEXT_LEN       = 5;

    localparam logic [7:0] CHAR_NL = 8'h0A;

    // Register byte addresses.
    localparam logic [2:0] ADDR_KEEP_DELIM = 3'd0;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slot_mask;
        logic [7:0]           tail_byte;
    } job_t;

    // Character idx of the "From " delimiter.
    function automatic logic [7:0] delim_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h46;   // F
            3'd1:    c = 8'h72;   // r
            3'd2:    c = 8'h6F;   // o
            3'd3:    c = 8'h6D;   // m
            3'd4:    c = 8'h20;   // space
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: design/mms_front.sv
// Front end of the mbox message splitter: tracks the line phase, classifies
// each input word and builds a job word for the back end. Uses mms_pkg.
module mms_front
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        keep_delimiter,
    input  logic        in_valid,      // word accepted this cycle
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        job_push,
    output mms_pkg::job_t job
);
    import mms_pkg::*;

    line_phase_t phase_reg, phase_next;
    logic        nonempty_reg, nonempty_next;

    logic [NUM_SLOTS-1:0] mask;
    logic [TEXT_LEN-1:0]  held_text;
    logic [TEXT_LEN-1:0]  full_text;
    logic                 byte_is_nl;
    logic                 char_hit;
    line_phase_t          after_byte;

    // Held prefix: first n characters of "From ".
    always_comb
    begin
        for (int i = 0; i < TEXT_LEN; i++)
        begin
            held_text[i] = (3'(i) < phase_reg);
        end
    end

    assign full_text  = '1;
    assign byte_is_nl = (data_byte == CHAR_NL);
    assign after_byte = byte_is_nl ? PH_START : PH_BODY;
    // next delimiter character expected in the start and prefix phases
    assign char_hit   = (data_byte == delim_char(phase_reg));

    // Next state
    always_comb
    begin
        phase_next    = phase_reg;
        nonempty_next = nonempty_reg;
        if (end_of_stream)
        begin
            phase_next    = PH_START;
            nonempty_next = 1'b0;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_START:
                begin
                    if (char_hit)
                    begin
                        phase_next = PH_F;
                    end
                    else
                    begin
                        phase_next    = after_byte;
                        nonempty_next = 1'b1;
                    end
                end
                PH_F, PH_FR, PH_FRO, PH_FROM:
                begin
                    if (char_hit)
                    begin
                        if (phase_reg == PH_FROM)
                        begin
                            phase_next    = PH_DELIM;
                            nonempty_next = keep_delimiter;
                        end
                        else
                        begin
                            phase_next = line_phase_t'(phase_reg + 3'd1);
                        end
                    end
                    else
                    begin
                        phase_next    = after_byte;
                        nonempty_next = 1'b1;
                    end
                end
                PH_DELIM:
                begin
                    if (keep_delimiter)
                    begin
                        nonempty_next = 1'b1;
                    end
                    if (byte_is_nl)
                    begin
                        phase_next = PH_START;
                    end
                end
                default:
                begin
                    phase_next    = after_byte;
                    nonempty_next = 1'b1;
                end
            endcase
        end
    end

    // Job slots
    always_comb
    begin
        mask = '0;
        if (end_of_stream)
        begin
            unique case (phase_reg) inside
                PH_F, PH_FR, PH_FRO, PH_FROM:
                begin
                    mask[SLOT_TEXT0 +: TEXT_LEN] = held_text;
                    mask[SLOT_TAIL]              = 1'b1;
                end
                PH_DELIM: mask[SLOT_TAIL] = keep_delimiter;
                PH_START: mask[SLOT_TAIL] = 1'b0;
                default:  mask[SLOT_TAIL] = 1'b1;
            endcase
            mask[SLOT_END_LAST] = nonempty_reg || mask[SLOT_TAIL];
        end
        else
        begin
            unique case (phase_reg) inside
                PH_START:
                begin
                    mask[SLOT_TAIL] = !char_hit;
                end
                PH_F, PH_FR, PH_FRO, PH_FROM:
                begin
                    if (char_hit)
                    begin
                        if (phase_reg == PH_FROM)
                        begin
                            mask[SLOT_END_FIRST] = nonempty_reg;
                            if (keep_delimiter)
                            begin
                                mask[SLOT_TEXT0 +: TEXT_LEN] = full_text;
                            end
                        end
                    end
                    else
                    begin
                        mask[SLOT_TEXT0 +: TEXT_LEN] = held_text;
                        mask[SLOT_TAIL]              = 1'b1;
                    end
                end
                PH_DELIM:
                begin
                    mask[SLOT_TAIL] = keep_delimiter;
                end
                default:
                begin
                    mask[SLOT_TAIL] = 1'b1;
                end
            endcase
        end
    end

    assign job.slot_mask = mask;
    assign job.tail_byte = end_of_stream ? CHAR_NL : data_byte;
    assign job_push      = in_valid && (mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            nonempty_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            phase_reg    <= phase_next;
            nonempty_reg <= nonempty_next;
        end
    end

endmodule

// File: design/mms_queue.sv
// Job queue between the front and back ends of the mbox message splitter.
// Small register FIFO with a combinational head. Uses mms_pkg.
module mms_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mms_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output mms_pkg::job_t head
);
    import mms_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: design/mms_back.sv
// Back end of the mbox message splitter: expands the job at the queue head
// into result words through an output register, one per cycle unless out_ready stalls. Uses mms_pkg.
module mms_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  mms_pkg::job_t job,
    output logic          job_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          message_end,
    output logic          last_of_run
);
    import mms_pkg::*;

    logic [NUM_SLOTS-1:0] done_reg, done_next;
    logic [NUM_SLOTS-1:0] remaining, lowest;
    logic [2:0]           slot_idx;
    logic                 can_load, issue, is_last;
    logic [7:0]           slot_byte;
    logic                 slot_end;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       last_reg;

    assign remaining = job.slot_mask & ~done_reg;
    assign lowest    = remaining & (~remaining + 1'b1);
    assign is_last   = ((remaining & ~lowest) == '0);
    assign can_load  = !valid_reg || out_ready;
    assign issue     = job_valid && can_load;
    assign job_pop   = issue && is_last;

    always_comb
    begin
        slot_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (lowest[i])
            begin
                slot_idx = 3'(i);
            end
        end
    end

    always_comb
    begin
        slot_end  = 1'b0;
        slot_byte = 8'h00;
        unique case (slot_idx) inside
            3'(SLOT_END_FIRST), 3'(SLOT_END_LAST): slot_end = 1'b1;
            3'(SLOT_TAIL):                         slot_byte = job.tail_byte;
            default: slot_byte = delim_char(3'(slot_idx - 3'(SLOT_TEXT0)));
        endcase
    end

    always_comb
    begin
        done_next = done_reg;
        if (job_pop)
        begin
            done_next = '0;
        end
        else if (issue)
        begin
            done_next = done_reg | lowest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (can_load)
            begin
                valid_reg <= job_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            byte_reg <= slot_byte;
            end_reg  <= slot_end;
            last_reg <= is_last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign message_end = end_reg;
    assign last_of_run = last_reg;

endmodule

// File: design/mbox_message_splitter.sv
// Top level of the mbox message splitter: stream ports, APB register and the
// front end, job queue and back end. Uses mms_pkg, mms_front, mms_queue, mms_back.
//
// Splits an mbox byte stream into messages at lines that begin with "From ".
// One input word is taken per cycle while the job queue has room; each word
// turns into a job of zero to six output words; the back end sends one output
// word per cycle unless m_tready holds it off. Unstalled, one input word per
// cycle is sustained when each yields at most one result; a word with more
// (a released "From" prefix, a kept delimiter, end of stream) emits them in
// turn. The output register and the QUEUE_DEPTH-entry job queue let the input
// keep running while output words wait. Input: s_tdata is the byte,
// s_tlast marks end of stream (no byte; held bytes are flushed, an open line
// gets a newline and the last message is closed). Output: m_tdata is the
// content byte, m_tuser marks a message end (m_tdata zero), m_tlast flags the
// final word caused by one input word. An empty message never gets an end
// word. Register 0 (byte address 0) bit 0 is keep_delimiter, reset 0: when
// set, each "From " line is kept at the head of its message. Write it only
// while the block is idle. No clearing pass after reset.
module mbox_message_splitter
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,     // end_of_stream
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] out_byte
    output logic        m_tuser,     // [0] message_end
    output logic        m_tlast,     // last_of_run
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mms_pkg::*;

    logic  keep_reg;
    logic  cfg_write;
    logic  in_accept;
    logic  job_push, job_pop, queue_full, queue_valid;
    job_t  new_job, head_job;

    // Register port: pready is held high, so transfers never wait.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == ADDR_KEEP_DELIM) ? {31'b0, keep_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg <= 1'b0;
        end
        else if (cfg_write && (paddr == ADDR_KEEP_DELIM))
        begin
            keep_reg <= pwdata[0];
        end
    end

    // Front end takes a word whenever the queue has room.
    assign s_tready  = !queue_full;
    assign in_accept = s_tvalid && s_tready;

    mms_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .keep_delimiter (keep_reg),
        .in_valid       (in_accept),
        .data_byte      (s_tdata),
        .end_of_stream  (s_tlast),
        .job_push       (job_push),
        .job            (new_job)
    );

    mms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (new_job),
        .pop       (job_pop),
        .full      (queue_full),
        .not_empty (queue_valid),
        .head      (head_job)
    );

    mms_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (queue_valid),
        .job         (head_job),
        .job_pop     (job_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .message_end (m_tuser),
        .last_of_run (m_tlast)
    );

endmodule

// File: dv/mbox_message_splitter_tb.sv
// Self-checking testbench for mbox_message_splitter: directed and random mbox byte
// streams against a built-in model of the splitter, with random stalls on both sides.
// Depends on mms_pkg and the mbox_message_splitter RTL; nothing else.
module mbox_message_splitter_tb;

    import mms_pkg::*;

    // "From " delimiter text, kept local to the predictor
    localparam logic [7:0] FROM_TXT [0:4] = '{8'h46, 8'h72, 8'h6F, 8'h6D, 8'h20};
    localparam logic [7:0] NL           = CHAR_NL;
    localparam int         DRAIN_CYCLES = 12;   // settle time after the last expected word
    localparam int         PRINT_CAP    = 30;   // mismatch lines printed before going quiet

    // One expected output word
    typedef struct packed {
        logic [7:0] data;
        logic       msg_end;
        logic       run_last;
    } out_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Splitter model state: line phase, open-message flag and the keep register copy
    line_phase_t phase_q  = PH_START;
    logic        msg_open = 1'b0;
    logic        keep_q   = 1'b0;

    out_word_t   pending_words[$];   // words the splitter still owes us, oldest first
    out_word_t   got_w;
    int          mismatch_cnt = 0;
    int          words_sent   = 0;
    int          src_idle_pct = 0;   // chance per cycle that the sender holds off
    int          snk_stall_pct = 0;  // chance per cycle that the receiver stalls

    mbox_message_splitter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [7:0] data_byte
        .s_tlast  (s_tlast),     // end_of_stream
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // [7:0] out_byte
        .m_tuser  (m_tuser),     // [0] message_end
        .m_tlast  (m_tlast),     // last_of_run
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // Splitter model
    // ------------------------------------------------------------------

    // Content byte: also marks the current message as having content
    function automatic void emit_byte(input logic [7:0] b);
        out_word_t w;
        w.data     = b;
        w.msg_end  = 1'b0;
        w.run_last = 1'b0;
        pending_words = {pending_words, w};
        msg_open = 1'b1;
    endfunction

    // Message end marker, suppressed for an empty message
    function automatic void emit_end();
        out_word_t w;
        if (msg_open)
        begin
            w.data     = 8'h00;
            w.msg_end  = 1'b1;
            w.run_last = 1'b0;
            pending_words = {pending_words, w};
            msg_open = 1'b0;
        end
    endfunction

    // Expected words for one accepted input word
    function automatic void split_predict(input logic [7:0] b, input logic eos);
        int         n0;
        int         k;
        logic [2:0] ph;
        n0 = pending_words.size();
        ph = phase_q;
        if (eos)
        begin
            case (phase_q)
                PH_F, PH_FR, PH_FRO, PH_FROM:
                begin
                    // held prefix comes out, then the line gets closed
                    for (k = 0; k < ph; k++)
                        emit_byte(FROM_TXT[k]);
                    emit_byte(NL);
                end
                PH_DELIM:
                begin
                    // a dropped delimiter line gets no newline
                    if (keep_q)
                        emit_byte(NL);
                end
                PH_START: ;
                default: emit_byte(NL);
            endcase
            emit_end();
            phase_q = PH_START;
        end
        else
        begin
            case (phase_q)
                PH_START:
                begin
                    if (b == FROM_TXT[0])
                        phase_q = PH_F;
                    else
                    begin
                        emit_byte(b);
                        phase_q = (b == NL) ? PH_START : PH_BODY;
                    end
                end
                PH_F, PH_FR, PH_FRO, PH_FROM:
                begin
                    if (b == FROM_TXT[ph])
                    begin
                        if (phase_q != PH_FROM)
                            phase_q = line_phase_t'(ph + 3'd1);
                        else
                        begin
                            // full delimiter: close message, keep value sampled now
                            emit_end();
                            if (keep_q)
                                for (k = 0; k < 5; k++)
                                    emit_byte(FROM_TXT[k]);
                            phase_q = PH_DELIM;
                        end
                    end
                    else
                    begin
                        // broken prefix: replay held bytes, then this one
                        for (k = 0; k < ph; k++)
                            emit_byte(FROM_TXT[k]);
                        emit_byte(b);
                        phase_q = (b == NL) ? PH_START : PH_BODY;
                    end
                end
                PH_DELIM:
                begin
                    if (keep_q)
                        emit_byte(b);
                    if (b == NL)
                        phase_q = PH_START;
                end
                default:
                begin
                    emit_byte(b);
                    phase_q = (b == NL) ? PH_START : PH_BODY;
                end
            endcase
        end
        if (pending_words.size() > n0)
            pending_words[pending_words.size() - 1].run_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on input handshake, then check output handshake.
    // Sampling at the rising edge sees pre-edge values of both sides.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                split_predict(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (pending_words.size() == 0)
                    report_mismatch($sformatf("unexpected word data=%02h end=%b last=%b",
                                              m_tdata, m_tuser, m_tlast));
                else
                begin
                    got_w = pending_words.pop_front();
                    if (m_tdata !== got_w.data || m_tuser !== got_w.msg_end ||
                        m_tlast !== got_w.run_last)
                        report_mismatch($sformatf(
                            "data=%02h end=%b last=%b, expected data=%02h end=%b last=%b",
                            m_tdata, m_tuser, m_tlast,
                            got_w.data, got_w.msg_end, got_w.run_last));
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        m_tready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------

    // One input word; returns right after the edge that accepted it
    task automatic send_word(input logic [7:0] b, input logic eos);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    // Hold off until every expected word has come out, plus settle time.
    // The first edge lets the monitor see the last accepted word.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write of keep_delimiter; only called with the splitter idle.
    // Upper data bits are random: only bit 0 is meaningful.
    task automatic write_keep(input logic v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_KEEP_DELIM;
        pwdata  <= {31'($urandom()), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        keep_q = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_idle(input int src_pct, input int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // Text-like byte: mostly delimiter letters, spaces and newlines, else anything
    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return FROM_TXT[$urandom_range(4)];
        else if (pick == 5)
            return NL;
        return 8'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Drop mode: empty stream, empty first message, byte extremes,
    // broken prefix, dropped delimiter at end of stream, held prefix at end
    task automatic test_directed_drop();
        write_keep(1'b0);
        send_word(8'h00, 1'b1);           // nothing open: no words at all
        send_text("From \n");             // delimiter before any content: no end marker
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(NL, 1'b0);
        send_text("Fx\n");                // prefix broken after one byte
        send_text("From z");              // closes message, line dropped
        send_word(8'hA5, 1'b1);           // dropped line: no newline, message empty
        send_text("Fro");
        send_word(8'h5A, 1'b1);           // held prefix flushed, newline, end
        wait_idle();
    endtask

    // Keep mode: delimiter line kept, six-word burst, newline at end of stream
    task automatic test_directed_keep();
        write_keep(1'b1);
        send_text("From a\n");
        send_word("b", 1'b0);
        send_text("From ");               // end marker plus the five kept bytes
        send_word(8'hFF, 1'b1);           // kept delimiter line gets its newline
        wait_idle();
    endtask

    // Keep value changes in the middle of a delimiter line
    task automatic test_keep_change();
        write_keep(1'b0);
        send_text("From ab");
        wait_idle();
        write_keep(1'b1);
        send_text("c\nd");
        send_word(8'h00, 1'b1);
        wait_idle();
        write_keep(1'b1);
        send_text("From x");
        wait_idle();
        write_keep(1'b0);
        send_text("y\n");
        send_word(8'h00, 1'b1);
        wait_idle();
    endtask

    // Mostly mbox-shaped lines (whole or broken "From " prefixes, random
    // content), some end-of-stream words and some raw noise bytes
    task automatic send_mbox_traffic(input int n);
        int stop_at;
        int pick;
        int plen;
        int blen;
        int k;
        stop_at = words_sent + n;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                plen = $urandom_range(8);
                if (plen > 5)
                    plen = 5;
                for (k = 0; k < plen; k++)
                    send_word(FROM_TXT[k], 1'b0);
                blen = $urandom_range(6);
                for (k = 0; k < blen; k++)
                    send_word(text_byte(), 1'b0);
                if ($urandom_range(9) != 0)
                    send_word(NL, 1'b0);
            end
            else if (pick < 80)
                send_word(8'($urandom_range(255)), 1'b1);
            else
                send_word(8'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic test_random_traffic();
        set_idle(0, 0);
        write_keep(1'b0);
        send_mbox_traffic(95);
        wait_idle();
        set_idle(49, 0);
        write_keep(1'b1);
        send_mbox_traffic(95);
        wait_idle();
        set_idle(0, 49);
        write_keep(1'b0);
        send_mbox_traffic(95);
        wait_idle();
        set_idle(13, 13);
        write_keep(1'b1);
        send_mbox_traffic(95);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_drop();
        test_directed_keep();
        test_keep_change();
        test_random_traffic();
        set_idle(0, 0);
        wait_idle();
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
